// ===== sv/analog_channel_report_scheduler_core_assert.svh =====
// Assertion macros for the analog channel report scheduler.
`ifndef ANALOG_CHANNEL_REPORT_SCHEDULER_CORE_ASSERT_SVH
`define ANALOG_CHANNEL_REPORT_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ACRS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acrs assertion failed");
`define ACRS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acrs assertion failed");
`else
`define ACRS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACRS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/acrs_pkg.sv =====
// Types and constants shared by the analog channel report scheduler.
`timescale 1ns / 1ps
package acrs_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   localparam logic CSR_HYST = 1'b0;
   localparam logic CSR_VREF = 1'b1;

   localparam logic [15:0] HYST_RESET  = 16'd1311;
   localparam logic [15:0] VREF_RESET  = 16'd3300;
   localparam logic [31:0] MS_PER_SEC  = 32'd1000;

   typedef struct packed {
      op_type      op;
      logic [7:0]  pin_id;
      logic [15:0] period_sec;
      logic        voltage_mode;
      logic [2:0]  slot_sel;
      logic [31:0] now_ms;
      logic [11:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic        report;
      logic [7:0]  event_pin;
      logic [15:0] event_value;
      logic        value_in_mv;
      logic [2:0]  slot_index;
      logic        op_ok;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic [7:0]  pin;
      logic [31:0] period_ms;
      logic        volt_mode;
      logic [15:0] last_value;
      logic [31:0] last_time;
   } slot_entry_type;

   typedef struct packed {
      logic        alloc;
      logic        free;
      logic        set_time;
      logic        set_value;
      logic [7:0]  pin;
      logic [31:0] period_ms;
      logic        volt_mode;
      logic [31:0] now_ms;
      logic [15:0] raw16;
   } tbl_cmd_type;

   typedef struct packed {
      logic        fire;
      logic        periodic;
      logic [15:0] value;
   } eval_type;

endpackage

// ===== sv/acrs_slot_table.sv =====
// Slot table: per-slot registers, free/match search and registered update.
`timescale 1ns / 1ps
module acrs_slot_table #(
   parameter int SLOTS = 8,
   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  acrs_pkg::tbl_cmd_type    cmd,
   input  logic [IdxW-1:0]          rd_idx,
   output acrs_pkg::slot_entry_type rd_entry,
   output logic                     free_found,
   output logic [IdxW-1:0]          free_idx,
   output logic                     match_found,
   output logic [IdxW-1:0]          match_idx
);

   acrs_pkg::slot_entry_type slot_ff [SLOTS];
   acrs_pkg::slot_entry_type slot_in [SLOTS];

   assign rd_entry = slot_ff[rd_idx];

   // lowest index wins
   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_ff[i].enabled) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
         if (slot_ff[i].enabled && (slot_ff[i].pin == cmd.pin)) begin
            match_found = 1'b1;
            match_idx   = IdxW'(i);
         end
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (cmd.alloc && free_found) begin
         slot_in[free_idx].enabled   = 1'b1;
         slot_in[free_idx].pin       = cmd.pin;
         slot_in[free_idx].period_ms = cmd.period_ms;
         slot_in[free_idx].volt_mode = cmd.volt_mode;
      end
      if (cmd.free && match_found) begin
         slot_in[match_idx].enabled    = 1'b0;
         slot_in[match_idx].last_value = '0;
         slot_in[match_idx].last_time  = '0;
      end
      if (cmd.set_time) begin
         slot_in[rd_idx].last_time = cmd.now_ms;
      end
      if (cmd.set_value) begin
         slot_in[rd_idx].last_value = cmd.raw16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '{default: '0};
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== sv/acrs_eval.sv =====
// Sample evaluation: period and change-band tests, millivolt scaling.
`timescale 1ns / 1ps
module acrs_eval (
   input  acrs_pkg::slot_entry_type entry,
   input  logic [15:0]              raw16,
   input  logic [31:0]              now_ms,
   input  logic [15:0]              hyst,
   input  logic [15:0]              vref,
   output acrs_pkg::eval_type       result
);

   logic [31:0] elapsed;
   logic [15:0] diff;
   logic [31:0] band;
   logic [31:0] mv_prod;
   logic        per_fire;
   logic        chg_fire;

   assign elapsed  = now_ms - entry.last_time;
   assign per_fire = elapsed > entry.period_ms;

   // |raw - prev| * 2^16 > prev * h  is the exact band test
   assign diff     = (raw16 >= entry.last_value) ? (raw16 - entry.last_value)
                                                 : (entry.last_value - raw16);
   assign band     = {16'b0, entry.last_value} * {16'b0, hyst};
   assign chg_fire = {diff, 16'h0000} > band;

   assign mv_prod  = {16'b0, raw16} * {16'b0, vref};

   assign result.periodic = entry.period_ms != 32'd0;
   assign result.fire     = result.periodic ? per_fire : chg_fire;
   assign result.value    = entry.volt_mode ? mv_prod[31:16] : raw16;

endmodule

// ===== sv/analog_channel_report_scheduler_core.sv =====
// A taken item is registered in req_ff, then its result in rsp_ff, shown with rsp_valid.
// One item per cycle unless busy; the slot table is read, tested and written at once.
// Results cannot be stalled; rsp_valid is high for exactly one cycle per item.
// Reset: synchronous; frees all slots, clears slot state, restores register defaults.
// busy is high only while reset is held.
`timescale 1ns / 1ps
`include "analog_channel_report_scheduler_core_assert.svh"
module analog_channel_report_scheduler_core #(
   parameter int SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  acrs_pkg::req_type req_item,
   output logic             rsp_valid,
   output acrs_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   acrs_pkg::req_type        req_ff;
   logic                     req_vld_ff;
   logic                     req_vld_in;
   acrs_pkg::rsp_type        rsp_ff;
   acrs_pkg::rsp_type        rsp_in;
   logic                     rsp_vld_ff;
   logic [15:0]              hyst_ff;
   logic [15:0]              vref_ff;

   acrs_pkg::tbl_cmd_type    cmd;
   acrs_pkg::slot_entry_type entry;
   acrs_pkg::eval_type       ev;
   logic                     free_found;
   logic [IdxW-1:0]          free_idx;
   logic                     match_found;
   logic [IdxW-1:0]          match_idx;
   logic [IdxW-1:0]          sel_idx;
   logic                     sel_ok;
   logic                     sample_live;
   logic [15:0]              raw16;

   assign busy       = reset;
   assign csr_ready  = 1'b1;
   assign req_vld_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         hyst_ff    <= acrs_pkg::HYST_RESET;
         vref_ff    <= acrs_pkg::VREF_RESET;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= req_vld_ff;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               acrs_pkg::CSR_HYST: hyst_ff <= csr_wdata;
               acrs_pkg::CSR_VREF: vref_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_in) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   assign raw16       = {req_ff.adc_sample, 4'b0000};
   assign sel_idx     = IdxW'(req_ff.slot_sel);
   assign sel_ok      = int'(req_ff.slot_sel) < SLOTS;
   assign sample_live = req_vld_ff && (req_ff.op == acrs_pkg::OP_SAMPLE)
                        && sel_ok && entry.enabled;

   always_comb begin
      cmd           = '0;
      cmd.alloc     = req_vld_ff && (req_ff.op == acrs_pkg::OP_ALLOC);
      cmd.free      = req_vld_ff && (req_ff.op == acrs_pkg::OP_FREE);
      cmd.set_time  = sample_live && ev.fire;
      cmd.set_value = sample_live && ev.fire && !ev.periodic;
      cmd.pin       = req_ff.pin_id;
      cmd.period_ms = {16'b0, req_ff.period_sec} * acrs_pkg::MS_PER_SEC;
      cmd.volt_mode = req_ff.voltage_mode;
      cmd.now_ms    = req_ff.now_ms;
      cmd.raw16     = raw16;
   end

   acrs_slot_table #(
      .SLOTS(SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_idx     (sel_idx),
      .rd_entry   (entry),
      .free_found (free_found),
      .free_idx   (free_idx),
      .match_found(match_found),
      .match_idx  (match_idx)
   );

   acrs_eval u_eval (
      .entry (entry),
      .raw16 (raw16),
      .now_ms(req_ff.now_ms),
      .hyst  (hyst_ff),
      .vref  (vref_ff),
      .result(ev)
   );

   always_comb begin
      rsp_in = '0;
      unique case (req_ff.op)
         acrs_pkg::OP_ALLOC: begin
            rsp_in.event_pin  = req_ff.pin_id;
            rsp_in.op_ok      = free_found;
            rsp_in.slot_index = free_found ? 3'(free_idx) : 3'd0;
         end
         acrs_pkg::OP_FREE: begin
            rsp_in.event_pin  = req_ff.pin_id;
            rsp_in.op_ok      = match_found;
            rsp_in.slot_index = match_found ? 3'(match_idx) : 3'd0;
         end
         acrs_pkg::OP_SAMPLE: begin
            rsp_in.slot_index = req_ff.slot_sel;
            if (sel_ok && entry.enabled) begin
               rsp_in.op_ok       = 1'b1;
               rsp_in.event_pin   = entry.pin;
               rsp_in.report      = ev.fire;
               rsp_in.event_value = ev.fire ? ev.value : 16'd0;
               rsp_in.value_in_mv = ev.fire && entry.volt_mode;
            end
         end
         acrs_pkg::OP_NOP: begin
            rsp_in = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   `ACRS_ASSERT_NXT(a_item_gives_rsp, clock, reset, start && !busy, ##1 rsp_valid)
   `ACRS_ASSERT_IMP(a_report_needs_ok, clock, reset, rsp_valid && rsp_item.report, rsp_item.op_ok)
   `ACRS_ASSERT_IMP(a_mv_needs_report, clock, reset, rsp_valid && rsp_item.value_in_mv, rsp_item.report)
   `ACRS_ASSERT_IMP(a_one_table_write, clock, reset, cmd.set_time, !cmd.alloc && !cmd.free)

endmodule

// ===== test/analog_channel_report_scheduler_core_test.sv =====
// Self-checking testbench for the analog channel report scheduler core.
`timescale 1ns / 1ps
module analog_channel_report_scheduler_core_test;

   localparam int SLOT_COUNT = 8;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   acrs_pkg::req_type req_item;
   logic rsp_valid;
   acrs_pkg::rsp_type rsp_item;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [15:0] csr_wdata;

   analog_channel_report_scheduler_core #(.SLOTS(SLOT_COUNT)) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // expected slot table and registers
   logic        tbl_enabled [SLOT_COUNT];
   logic [7:0]  tbl_pin [SLOT_COUNT];
   logic [31:0] tbl_period_ms [SLOT_COUNT];
   logic        tbl_volt [SLOT_COUNT];
   logic [15:0] tbl_last_value [SLOT_COUNT];
   logic [31:0] tbl_last_time [SLOT_COUNT];
   logic [15:0] hyst_cfg;
   logic [15:0] vref_cfg;

   acrs_pkg::rsp_type pending_events [$];
   acrs_pkg::rsp_type want_event;
   int items_taken;
   int csr_taken;
   int results_seen;
   int reports_seen;
   int err_count;
   int max_gap;
   logic [31:0] clock_ms;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #1_000_000;
      $display("FAIL analog_channel_report_scheduler_core");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (err_count < 40)
         $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      err_count++;
   endtask

   task automatic check_event(input acrs_pkg::rsp_type got, input acrs_pkg::rsp_type want);
      if (got.report !== want.report)
         report_mismatch("report", 32'(got.report), 32'(want.report));
      if (got.event_pin !== want.event_pin)
         report_mismatch("event_pin", 32'(got.event_pin), 32'(want.event_pin));
      if (got.event_value !== want.event_value)
         report_mismatch("event_value", 32'(got.event_value), 32'(want.event_value));
      if (got.value_in_mv !== want.value_in_mv)
         report_mismatch("value_in_mv", 32'(got.value_in_mv), 32'(want.value_in_mv));
      if (got.slot_index !== want.slot_index)
         report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
      if (got.op_ok !== want.op_ok)
         report_mismatch("op_ok", 32'(got.op_ok), 32'(want.op_ok));
   endtask

   function automatic acrs_pkg::rsp_type predict_slot_event(input acrs_pkg::req_type r);
      acrs_pkg::rsp_type e;
      logic [15:0] raw;
      logic [63:0] scaled;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] elapsed;
      logic [31:0] prod;
      logic fire;
      int idx;
      int i;
      e = '0;
      raw = {r.adc_sample, 4'b0000};
      fire = 1'b0;
      idx = -1;
      case (r.op)
         acrs_pkg::OP_ALLOC: begin
            for (i = 0; i < SLOT_COUNT; i++)
               if (idx < 0 && !tbl_enabled[i]) idx = i;
            e.event_pin = r.pin_id;
            if (idx >= 0) begin
               tbl_enabled[idx] = 1'b1;
               tbl_pin[idx] = r.pin_id;
               tbl_period_ms[idx] = 32'(r.period_sec) * acrs_pkg::MS_PER_SEC;
               tbl_volt[idx] = r.voltage_mode;
               e.slot_index = idx[2:0];
               e.op_ok = 1'b1;
            end
         end
         acrs_pkg::OP_FREE: begin
            for (i = 0; i < SLOT_COUNT; i++)
               if (idx < 0 && tbl_enabled[i] && tbl_pin[i] == r.pin_id) idx = i;
            e.event_pin = r.pin_id;
            if (idx >= 0) begin
               tbl_enabled[idx] = 1'b0;
               tbl_last_value[idx] = '0;
               tbl_last_time[idx] = '0;
               e.slot_index = idx[2:0];
               e.op_ok = 1'b1;
            end
         end
         acrs_pkg::OP_SAMPLE: begin
            idx = int'(r.slot_sel);
            e.slot_index = r.slot_sel;
            if (tbl_enabled[idx]) begin
               e.op_ok = 1'b1;
               e.event_pin = tbl_pin[idx];
               if (tbl_period_ms[idx] != 0) begin
                  elapsed = r.now_ms - tbl_last_time[idx];
                  if (elapsed > tbl_period_ms[idx]) begin
                     fire = 1'b1;
                     tbl_last_time[idx] = r.now_ms;
                  end
               end else begin
                  scaled = 64'(raw) << 16;
                  hi = 64'(tbl_last_value[idx]) * (64'd65536 + 64'(hyst_cfg));
                  lo = 64'(tbl_last_value[idx]) * (64'd65536 - 64'(hyst_cfg));
                  if (scaled > hi || scaled < lo) begin
                     fire = 1'b1;
                     tbl_last_value[idx] = raw;
                     tbl_last_time[idx] = r.now_ms;
                  end
               end
               if (fire) begin
                  e.report = 1'b1;
                  e.value_in_mv = tbl_volt[idx];
                  prod = 32'(raw) * 32'(vref_cfg);
                  e.event_value = tbl_volt[idx] ? prod[31:16] : raw;
               end
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_enabled[i] = 1'b0;
            tbl_pin[i] = '0;
            tbl_period_ms[i] = '0;
            tbl_volt[i] = 1'b0;
            tbl_last_value[i] = '0;
            tbl_last_time[i] = '0;
         end
         hyst_cfg = acrs_pkg::HYST_RESET;
         vref_cfg = acrs_pkg::VREF_RESET;
      end else begin
         if (rsp_valid === 1'b1) begin
            results_seen++;
            if (rsp_item.report === 1'b1) reports_seen++;
            if (pending_events.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(rsp_item), 32'd0);
            end else begin
               want_event = pending_events.pop_front();
               check_event(rsp_item, want_event);
            end
         end
         if (start && !busy) begin
            pending_events.push_back(predict_slot_event(req_item));
            items_taken++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == acrs_pkg::CSR_HYST)
               hyst_cfg = csr_wdata;
            else
               vref_cfg = csr_wdata;
            csr_taken++;
         end
      end
   end

   function automatic acrs_pkg::req_type make_req(input acrs_pkg::op_type op,
                                                  input logic [7:0] pin,
                                                  input logic [15:0] period,
                                                  input logic vmode,
                                                  input logic [2:0] sel,
                                                  input logic [31:0] now,
                                                  input logic [11:0] adc);
      acrs_pkg::req_type r;
      r.op = op;
      r.pin_id = pin;
      r.period_sec = period;
      r.voltage_mode = vmode;
      r.slot_sel = sel;
      r.now_ms = now;
      r.adc_sample = adc;
      return r;
   endfunction

   task automatic send_item(input acrs_pkg::req_type r);
      int gap;
      int n;
      gap = $urandom_range(0, max_gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= r;
      n = items_taken;
      wait (items_taken != n);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      start <= 1'b0;
      while (pending_events.size() != 0 && waited < 64) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] data);
      int n;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      n = csr_taken;
      wait (csr_taken != n);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_slots();
      max_gap = 16;
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd3, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd0, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd255, 16'hFFFF, 1'b1, 3'd7, 32'hFFFF_FFFF,
                         12'hFFF));
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd7, 16'd1, 1'b1, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd7, 16'd0, 1'b1, 3'd0, 32'd0, 12'd0));
      for (int p = 10; p < 14; p++)
         send_item(make_req(acrs_pkg::OP_ALLOC, 8'(p), 16'd2, 1'b0, 3'd0, 32'd0, 12'd0));
      // table full
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd20, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_FREE, 8'd99, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      // change slot starting from zero
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'hFFFF_FFFF,
                         12'hFFF));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd5, 12'hFFF));
      // periodic slot: equal to period does not fire, one more does, then wrap
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd2, 32'd1000, 12'h800));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd2, 32'd1001, 12'h800));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd2, 32'd0, 12'hFFF));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd3, 32'd0, 12'hFFF));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd1, 32'hFFFF_FFFF,
                         12'h001));
      // duplicate pin frees the lowest slot, which is then reused
      send_item(make_req(acrs_pkg::OP_FREE, 8'd7, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd30, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd2, 32'd77, 12'd1));
      send_item(make_req(acrs_pkg::OP_NOP, 8'hFF, 16'hFFFF, 1'b1, 3'd7, 32'hFFFF_FFFF,
                         12'hFFF));
      send_item(make_req(acrs_pkg::OP_FREE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd0, 12'hFFF));
   endtask

   task automatic test_register_extremes();
      wait_drained();
      csr_write(acrs_pkg::CSR_HYST, 16'd0);
      csr_write(acrs_pkg::CSR_VREF, 16'hFFFF);
      max_gap = 2;
      // slot 0 is free after the directed part
      send_item(make_req(acrs_pkg::OP_ALLOC, 8'd40, 16'd0, 1'b1, 3'd0, 32'd0, 12'd0));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd1, 12'h100));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd2, 12'h100));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd3, 12'h101));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd4, 12'hFFF));
      wait_drained();
      csr_write(acrs_pkg::CSR_HYST, 16'hFFFF);
      csr_write(acrs_pkg::CSR_VREF, 16'd0);
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd5, 12'd0));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd6, 12'd1));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd7, 12'd3));
      send_item(make_req(acrs_pkg::OP_SAMPLE, 8'd0, 16'd0, 1'b0, 3'd0, 32'd8, 12'hFFF));
      wait_drained();
   endtask

   function automatic logic [7:0] random_pin();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 11));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic acrs_pkg::req_type random_item();
      acrs_pkg::req_type r;
      int pick;
      int n_on;
      int sel;
      int prev;
      int band;
      int v;
      n_on = 0;
      for (int i = 0; i < SLOT_COUNT; i++)
         if (tbl_enabled[i]) n_on++;
      r = make_req(acrs_pkg::OP_NOP, random_pin(), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   $urandom, 12'($urandom_range(0, 4095)));
      pick = $urandom_range(0, 99);
      if (pick < (n_on < 3 ? 40 : 12)) begin
         r.op = acrs_pkg::OP_ALLOC;
         pick = $urandom_range(0, 9);
         if (pick < 5) r.period_sec = '0;
         else if (pick < 9) r.period_sec = 16'($urandom_range(1, 4));
      end else if (pick < 30) begin
         r.op = acrs_pkg::OP_FREE;
         sel = $urandom_range(0, SLOT_COUNT - 1);
         if ($urandom_range(0, 9) < 7 && tbl_enabled[sel]) r.pin_id = tbl_pin[sel];
      end else if (pick < 96) begin
         r.op = acrs_pkg::OP_SAMPLE;
         if ($urandom_range(0, 99) < 5)
            clock_ms = $urandom;
         else
            clock_ms = clock_ms + 32'($urandom_range(0, 3000));
         r.now_ms = clock_ms;
         sel = $urandom_range(0, SLOT_COUNT - 1);
         if ($urandom_range(0, 99) < 85)
            for (int i = 0; i < SLOT_COUNT; i++)
               if (tbl_enabled[(sel + i) % SLOT_COUNT] && !tbl_enabled[sel])
                  sel = (sel + i) % SLOT_COUNT;
         r.slot_sel = 3'(sel);
         if ($urandom_range(0, 99) < 60) begin
            // land around the change band edges
            prev = int'(tbl_last_value[sel]);
            band = int'((longint'(prev) * longint'(hyst_cfg)) >>> 16);
            v = prev + int'($urandom_range(0, 2 * band + 64)) - band - 32;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            r.adc_sample = 12'(v >> 4);
         end
      end
      return r;
   endfunction

   task automatic test_random_traffic();
      logic [15:0] hyst_set [5];
      logic [15:0] vref_set [5];
      int gap_set [5];
      hyst_set = '{16'd0, 16'hFFFF, 16'($urandom), acrs_pkg::HYST_RESET,
                   16'($urandom_range(0, 4000))};
      vref_set = '{16'hFFFF, 16'd0, 16'($urandom), acrs_pkg::VREF_RESET, 16'($urandom)};
      gap_set = '{16, 0, 16, 4, 16};
      clock_ms = 32'd100;
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         csr_write(acrs_pkg::CSR_HYST, hyst_set[ph]);
         csr_write(acrs_pkg::CSR_VREF, vref_set[ph]);
         max_gap = gap_set[ph];
         repeat (110) send_item(random_item());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = acrs_pkg::CSR_HYST;
      csr_wdata = '0;
      items_taken = 0;
      csr_taken = 0;
      results_seen = 0;
      reports_seen = 0;
      err_count = 0;
      max_gap = 16;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_slots();
      test_register_extremes();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0)
         report_mismatch("results never arrived", 32'(pending_events.size()), 32'd0);
      $display("Run covered %0d items, %0d results with %0d reports, %0d register writes",
               items_taken, results_seen, reports_seen, csr_taken);
      $display("over alloc, free, sample and no-op items with %0d mismatches", err_count);
      if (err_count == 0)
         $display("PASS analog_channel_report_scheduler_core");
      else
         $display("FAIL analog_channel_report_scheduler_core");
      $finish;
   end

endmodule

// ===== analog_channel_report_scheduler_core.f =====
+incdir+sv
sv/acrs_pkg.sv
sv/acrs_slot_table.sv
sv/acrs_eval.sv
sv/analog_channel_report_scheduler_core.sv
test/analog_channel_report_scheduler_core_test.sv
